@@ src/dtc_pkg.sv @@
// Shared types, register codes and reset values for the disciplined timestamp clock.
package dtc_pkg;

  localparam int unsigned TimeW   = 64;
  localparam int unsigned SecW    = 32;
  localparam int unsigned DriftW  = 8;
  localparam int unsigned StepW   = 7;
  localparam int unsigned ActW    = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 32;

  localparam logic [TimeW-1:0]  ClockReset   = 64'hBBF8_1DFF_4407_E200;
  localparam logic [DriftW-1:0] DriftReset   = 8'hC0;
  localparam logic [SecW-1:0]   RefreshReset = '0;
  localparam logic [7:0]        LastReqReset = '0;

  localparam logic [23:0] BaseIncReset   = 24'd214784;
  localparam logic [6:0]  DriftStepReset = 7'd10;
  localparam logic [31:0] OffLimitReset  = 32'd2147483;
  localparam logic [15:0] RefIntReset    = 16'd30;
  localparam logic [7:0]  RetrySpReset   = 8'd15;
  localparam logic [15:0] RspTmoReset    = 16'd180;
  localparam logic [15:0] BackoffReset   = 16'd60;
  localparam logic [31:0] UnsyncReset    = 32'd65536;

  typedef enum logic [ActW-1:0] {
    ACT_TICK = 2'd0,
    ACT_SET  = 2'd1,
    ACT_POLL = 2'd2,
    ACT_HOLD = 2'd3
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BASE_INC   = 3'd0,
    REG_DRIFT_STEP = 3'd1,
    REG_OFF_LIMIT  = 3'd2,
    REG_REF_INT    = 3'd3,
    REG_RETRY_SP   = 3'd4,
    REG_RSP_TMO    = 3'd5,
    REG_BACKOFF    = 3'd6,
    REG_UNSYNC     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [23:0] base_increment;
    logic [6:0]  drift_step;
    logic [31:0] offset_limit;
    logic [15:0] refresh_interval;
    logic [7:0]  retry_spacing;
    logic [15:0] response_timeout;
    logic [15:0] timeout_backoff;
    logic [31:0] unsynced_below;
  } cfg_t;

endpackage

@@ src/dtc_if.sv @@
// Request and result channel interfaces of the disciplined timestamp clock.
interface dtc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [63:0] new_time;

  modport source (output valid, output action, output new_time, input ready);
  modport sink   (input valid, input action, input new_time, output ready);
endinterface

interface dtc_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] time_now;
  logic [7:0]  drift_now;
  logic        send_request;
  logic        response_timed_out;

  modport source (output valid, output time_now, output drift_now, output send_request,
                  output response_timed_out, input ready);
  modport sink   (input valid, input time_now, input drift_now, input send_request,
                  input response_timed_out, output ready);
endinterface

@@ src/disciplined_timestamp_clock_core.sv @@
// An accepted request goes to the request register and its result to the result register.
// Throughput: one request per cycle; the clock state update is one 64-bit add,
// subtract and compare between the request register and the result register.
// A waiting result blocks a new request only once the request register is also full.
// Reset (async, active low) restores the clock, drift trim, refresh marks and registers
// to their defaults and empties both stages.
module disciplined_timestamp_clock_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  dtc_req_if.sink    in_i,
  dtc_rsp_if.source  out_o
);
  import dtc_pkg::*;

  cfg_t cfg;

  dtc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dtc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req    (in_i),
    .rsp    (out_o)
  );

endmodule

@@ src/dtc_cfg.sv @@
// Configuration register bank of the disciplined timestamp clock.
module dtc_cfg (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [2:0]              cfg_index_i,
  input  logic [31:0]             cfg_wdata_i,
  output dtc_pkg::cfg_t           cfg_o
);
  import dtc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_increment   <= BaseIncReset;
      cfg_q.drift_step       <= DriftStepReset;
      cfg_q.offset_limit     <= OffLimitReset;
      cfg_q.refresh_interval <= RefIntReset;
      cfg_q.retry_spacing    <= RetrySpReset;
      cfg_q.response_timeout <= RspTmoReset;
      cfg_q.timeout_backoff  <= BackoffReset;
      cfg_q.unsynced_below   <= UnsyncReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_BASE_INC:   cfg_q.base_increment   <= cfg_wdata_i[23:0];
        REG_DRIFT_STEP: cfg_q.drift_step       <= cfg_wdata_i[6:0];
        REG_OFF_LIMIT:  cfg_q.offset_limit     <= cfg_wdata_i;
        REG_REF_INT:    cfg_q.refresh_interval <= cfg_wdata_i[15:0];
        REG_RETRY_SP:   cfg_q.retry_spacing    <= cfg_wdata_i[7:0];
        REG_RSP_TMO:    cfg_q.response_timeout <= cfg_wdata_i[15:0];
        REG_BACKOFF:    cfg_q.timeout_backoff  <= cfg_wdata_i[15:0];
        REG_UNSYNC:     cfg_q.unsynced_below   <= cfg_wdata_i;
        default:        cfg_q.unsynced_below   <= cfg_q.unsynced_below;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/dtc_core.sv @@
// Request register, clock state update and result register.
module dtc_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dtc_pkg::cfg_t cfg_i,
  dtc_req_if.sink       req,
  dtc_rsp_if.source     rsp
);
  import dtc_pkg::*;

  // request stage
  logic              in_vld_q;
  logic [ActW-1:0]   act_q;
  logic [TimeW-1:0]  ntime_q;

  // clock state
  logic [TimeW-1:0]  clock_q, clock_d;
  logic [DriftW-1:0] drift_q, drift_d;
  logic [SecW-1:0]   refresh_q, refresh_d;
  logic [7:0]        last_req_q, last_req_d;

  // result stage
  logic              out_vld_q;
  logic [TimeW-1:0]  time_q;
  logic [DriftW-1:0] drift_out_q;
  logic              send_q, send_d;
  logic              tmo_q, tmo_d;

  logic              advance;
  logic [TimeW-1:0]  diff;
  logic [SecW-1:0]   neg_limit;
  logic              pos_big, neg_big;
  logic [SecW-1:0]   sec, age;
  logic [7:0]        since;
  logic              want_req;

  assign advance   = in_vld_q && (!out_vld_q || rsp.ready);
  assign req.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req.ready) begin
      in_vld_q <= req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      act_q   <= req.action;
      ntime_q <= req.new_time;
    end
  end

  // Offset test without negating the difference: compare against -limit instead.
  assign diff      = ntime_q - clock_q;
  assign neg_limit = SecW'(~cfg_i.offset_limit + 32'd1);
  assign pos_big   = !diff[63] && ((|diff[62:32]) || (diff[31:0] > cfg_i.offset_limit));
  assign neg_big   = diff[63] && ((cfg_i.offset_limit == '0) || !(&diff[62:32]) ||
                                  (diff[31:0] < neg_limit));

  assign sec      = clock_q[63:32];
  assign age      = sec - refresh_q;
  assign since    = sec[7:0] - last_req_q;
  assign want_req = (age > SecW'(cfg_i.refresh_interval)) || (sec < cfg_i.unsynced_below);

  always_comb begin
    clock_d    = clock_q;
    drift_d    = drift_q;
    refresh_d  = refresh_q;
    last_req_d = last_req_q;
    send_d     = 1'b0;
    tmo_d      = 1'b0;
    unique case (action_e'(act_q))
      ACT_TICK: begin
        clock_d = clock_q + TimeW'(cfg_i.base_increment) + TimeW'(drift_q);
      end
      ACT_SET: begin
        clock_d   = ntime_q;
        refresh_d = ntime_q[63:32];
        if (pos_big) begin
          drift_d = drift_q + {1'b0, cfg_i.drift_step};
        end else if (neg_big) begin
          drift_d = drift_q - {1'b0, cfg_i.drift_step};
        end
      end
      ACT_POLL: begin
        if (want_req && (since > cfg_i.retry_spacing)) begin
          last_req_d = sec[7:0];
          send_d     = 1'b1;
        end
        if (want_req && (age > SecW'(cfg_i.response_timeout))) begin
          refresh_d = sec - SecW'(cfg_i.timeout_backoff);
          tmo_d     = 1'b1;
        end
      end
      ACT_HOLD: begin
        clock_d = clock_q;
      end
      default: begin
        clock_d = clock_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q    <= ClockReset;
      drift_q    <= DriftReset;
      refresh_q  <= RefreshReset;
      last_req_q <= LastReqReset;
    end else if (advance) begin
      clock_q    <= clock_d;
      drift_q    <= drift_d;
      refresh_q  <= refresh_d;
      last_req_q <= last_req_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (rsp.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      time_q      <= clock_d;
      drift_out_q <= drift_d;
      send_q      <= send_d;
      tmo_q       <= tmo_d;
    end
  end

  assign rsp.valid              = out_vld_q;
  assign rsp.time_now           = time_q;
  assign rsp.drift_now          = drift_out_q;
  assign rsp.send_request       = send_q;
  assign rsp.response_timed_out = tmo_q;

endmodule

@@ src/dtc_checker.sv @@
// Port-level checks of the disciplined timestamp clock, bound to the top level.
module dtc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_time,
  input logic [7:0]  out_drift,
  input logic        out_send,
  input logic        out_tmo
);

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_time) && $stable(out_drift) &&
                                $stable(out_send) && $stable(out_tmo))
    else $error("stalled result changed");

  // request side stalls only behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid && !out_ready)
    else $error("request stalled with result side free");

  // no result in the cycle after a reset edge
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid)
    else $error("result valid during reset");

  // an accepted request with no result waiting is followed by a valid result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && !out_valid |=> ##1 out_valid)
    else $error("result missing after request");

endmodule

bind disciplined_timestamp_clock_core dtc_checker u_dtc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_time  (out_o.time_now),
  .out_drift (out_o.drift_now),
  .out_send  (out_o.send_request),
  .out_tmo   (out_o.response_timed_out)
);

@@ tb/disciplined_timestamp_clock_core_test.sv @@
// Self-checking testbench for the disciplined timestamp clock core.
module disciplined_timestamp_clock_core_test;
  import dtc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    action_e     action;
    logic [63:0] new_time;
    logic        relative;  // new_time is an offset from the clock at issue
  } clock_cmd_t;

  typedef struct packed {
    logic [63:0] time_now;
    logic [7:0]  drift_now;
    logic        send_request;
    logic        response_timed_out;
  } clock_rsp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  dtc_req_if req_ch ();
  dtc_rsp_if rsp_ch ();

  disciplined_timestamp_clock_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (req_ch),
    .out_o       (rsp_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Timekeeper model state and register copy
  cfg_t        clk_cfg;
  logic [63:0] clock_state;
  logic [7:0]  drift_trim;
  logic [31:0] refresh_sec;
  logic [7:0]  last_req_sec;

  clock_cmd_t pending_cmds[$];
  clock_rsp_t expected_stamps[$];
  clock_cmd_t cur_cmd;
  int         mismatch_count = 0;
  int         gap_pct = 0;
  int         stall_pct = 0;
  int         gap_left = 0;
  int         stall_left = 0;

  task automatic step_timekeeper(input clock_cmd_t cmd, output clock_rsp_t rsp);
    logic [63:0] diff;
    logic [63:0] mag;
    logic [31:0] sec;
    logic [31:0] age;
    logic [7:0]  since;
    rsp = '0;
    case (cmd.action)
      ACT_TICK: begin
        clock_state = clock_state + {40'd0, clk_cfg.base_increment} + {56'd0, drift_trim};
      end
      ACT_SET: begin
        diff = cmd.new_time - clock_state;
        mag  = diff[63] ? (64'd0 - diff) : diff;
        // Step the trim only when the offset is beyond the limit, either sign
        if (mag > {32'd0, clk_cfg.offset_limit}) begin
          if (diff[63]) drift_trim = drift_trim - {1'b0, clk_cfg.drift_step};
          else drift_trim = drift_trim + {1'b0, clk_cfg.drift_step};
        end
        clock_state = cmd.new_time;
        refresh_sec = cmd.new_time[63:32];
      end
      ACT_POLL: begin
        sec = clock_state[63:32];
        age = sec - refresh_sec;
        if (age > {16'd0, clk_cfg.refresh_interval} || sec < clk_cfg.unsynced_below) begin
          since = sec[7:0] - last_req_sec;
          if (since > clk_cfg.retry_spacing) begin
            last_req_sec = sec[7:0];
            rsp.send_request = 1'b1;
          end
          if (age > {16'd0, clk_cfg.response_timeout}) begin
            refresh_sec = sec - {16'd0, clk_cfg.timeout_backoff};
            rsp.response_timed_out = 1'b1;
          end
        end
      end
      default: ;
    endcase
    rsp.time_now  = clock_state;
    rsp.drift_now = drift_trim;
  endtask

  // Request driver: one request offered at a time, relative offsets resolved at issue
  always @(posedge clk) begin
    clock_rsp_t exp_rsp;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        step_timekeeper(cur_cmd, exp_rsp);
        expected_stamps.push_back(exp_rsp);
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_cmds.size() > 0 && $urandom_range(99) < gap_pct) begin
          gap_left = $urandom_range(3);
          req_ch.valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          if (cur_cmd.relative) begin
            cur_cmd.new_time = clock_state + cur_cmd.new_time;
            cur_cmd.relative = 1'b0;
          end
          req_ch.valid    <= 1'b1;
          req_ch.action   <= cur_cmd.action;
          req_ch.new_time <= cur_cmd.new_time;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin
    clock_rsp_t want;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_stamps.size() == 0) begin
          $error("unexpected result: time_now %h drift_now %0d", rsp_ch.time_now,
                 rsp_ch.drift_now);
          mismatch_count++;
        end else begin
          want = expected_stamps.pop_front();
          if (rsp_ch.time_now !== want.time_now) begin
            $error("time_now: expected %h, actual %h", want.time_now, rsp_ch.time_now);
            mismatch_count++;
          end
          if (rsp_ch.drift_now !== want.drift_now) begin
            $error("drift_now: expected %0d, actual %0d", want.drift_now, rsp_ch.drift_now);
            mismatch_count++;
          end
          if (rsp_ch.send_request !== want.send_request) begin
            $error("send_request: expected %0d, actual %0d", want.send_request,
                   rsp_ch.send_request);
            mismatch_count++;
          end
          if (rsp_ch.response_timed_out !== want.response_timed_out) begin
            $error("response_timed_out: expected %0d, actual %0d", want.response_timed_out,
                   rsp_ch.response_timed_out);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(3);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  function automatic clock_cmd_t make_cmd(action_e act, logic [63:0] t, logic rel);
    clock_cmd_t c;
    c.action   = act;
    c.new_time = t;
    c.relative = rel;
    return c;
  endfunction

  function automatic logic [31:0] reg_mask(cfg_idx_e idx);
    case (idx)
      REG_BASE_INC:   return 32'h00FF_FFFF;
      REG_DRIFT_STEP: return 32'h0000_007F;
      REG_REF_INT,
      REG_RSP_TMO,
      REG_BACKOFF:    return 32'h0000_FFFF;
      REG_RETRY_SP:   return 32'h0000_00FF;
      default:        return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic clock_cmd_t random_cmd();
    clock_cmd_t  c;
    int unsigned pick;
    logic [63:0] lim;
    pick = $urandom_range(99);
    lim  = {32'd0, clk_cfg.offset_limit};
    c    = make_cmd(ACT_TICK, {$urandom, $urandom}, 1'b0);
    if (pick >= 35 && pick < 65) begin
      c.action = ACT_POLL;
    end else if (pick >= 65 && pick < 95) begin
      c.action = ACT_SET;
      case ($urandom_range(4))
        0: ;
        1: begin
          // land right around the offset limit
          c.relative = 1'b1;
          c.new_time = lim + 64'($urandom_range(2)) - 64'd1;
          if ($urandom_range(1)) c.new_time = 64'd0 - c.new_time;
        end
        2: begin
          c.relative = 1'b1;
          c.new_time = {44'd0, 20'($urandom)};
          if ($urandom_range(1)) c.new_time = 64'd0 - c.new_time;
        end
        3: c.new_time = {$urandom, 8'hFF, 24'($urandom)};
        default: begin
          c.relative = 1'b1;
          if ($urandom_range(3) == 0) c.new_time = 64'h8000_0000_0000_0000;
          else c.new_time = {30'd0, 2'($urandom), 8'hFF, 24'($urandom)};
        end
      endcase
    end else if (pick >= 95) begin
      c.action = ACT_HOLD;
    end
    return c;
  endfunction

  task automatic queue_random_cmds(input int count);
    int run;
    while (count > 0) begin
      if ($urandom_range(19) == 0) begin
        // long tick runs can carry the seconds over
        run = $urandom_range(64, 16);
        repeat (run) pending_cmds.push_back(make_cmd(ACT_TICK, {$urandom, $urandom}, 1'b0));
        pending_cmds.push_back(make_cmd(ACT_POLL, {$urandom, $urandom}, 1'b0));
        count = count - run - 1;
      end else begin
        pending_cmds.push_back(random_cmd());
        count = count - 1;
      end
    end
  endtask

  task automatic queue_directed_cmds();
    logic [63:0] lim;
    lim = {32'd0, clk_cfg.offset_limit};
    pending_cmds.push_back(make_cmd(ACT_POLL, '0, 1'b0));
    pending_cmds.push_back(make_cmd(ACT_POLL, '1, 1'b0));
    pending_cmds.push_back(make_cmd(ACT_TICK, '0, 1'b0));
    pending_cmds.push_back(make_cmd(ACT_HOLD, '0, 1'b0));
    pending_cmds.push_back(make_cmd(ACT_SET, lim, 1'b1));
    pending_cmds.push_back(make_cmd(ACT_SET, lim + 64'd1, 1'b1));
    pending_cmds.push_back(make_cmd(ACT_SET, 64'd0 - lim, 1'b1));
    pending_cmds.push_back(make_cmd(ACT_SET, 64'd0 - lim - 64'd1, 1'b1));
    // most negative offset
    pending_cmds.push_back(make_cmd(ACT_SET, 64'h8000_0000_0000_0000, 1'b1));
    pending_cmds.push_back(make_cmd(ACT_SET, 64'd0, 1'b0));
    pending_cmds.push_back(make_cmd(ACT_POLL, '0, 1'b0));
    pending_cmds.push_back(make_cmd(ACT_TICK, '1, 1'b0));
    pending_cmds.push_back(make_cmd(ACT_SET, '1, 1'b0));
    pending_cmds.push_back(make_cmd(ACT_TICK, '0, 1'b0));
    pending_cmds.push_back(make_cmd(ACT_POLL, '0, 1'b0));
    pending_cmds.push_back(make_cmd(ACT_SET, 64'h0000_0001_FFFF_FFFF, 1'b0));
    pending_cmds.push_back(make_cmd(ACT_TICK, '0, 1'b0));
    pending_cmds.push_back(make_cmd(ACT_POLL, '0, 1'b0));
    pending_cmds.push_back(make_cmd(ACT_SET, 64'd0, 1'b1));
    pending_cmds.push_back(make_cmd(ACT_HOLD, {$urandom, $urandom}, 1'b0));
    pending_cmds.push_back(make_cmd(ACT_POLL, '0, 1'b0));
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_BASE_INC:   clk_cfg.base_increment   = data[23:0];
      REG_DRIFT_STEP: clk_cfg.drift_step       = data[6:0];
      REG_OFF_LIMIT:  clk_cfg.offset_limit     = data;
      REG_REF_INT:    clk_cfg.refresh_interval = data[15:0];
      REG_RETRY_SP:   clk_cfg.retry_spacing    = data[7:0];
      REG_RSP_TMO:    clk_cfg.response_timeout = data[15:0];
      REG_BACKOFF:    clk_cfg.timeout_backoff  = data[15:0];
      REG_UNSYNC:     clk_cfg.unsynced_below   = data;
      default: ;
    endcase
  endtask

  task automatic program_phase(input int phase);
    logic [31:0] vals [8];
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(3))
        0: vals[i] = '0;
        1: vals[i] = reg_mask(cfg_idx_e'(i));
        2: vals[i] = $urandom & reg_mask(cfg_idx_e'(i));
        default: vals[i] = $urandom;  // upper bits beyond the field are dropped
      endcase
      if (phase == 0) vals[i] = '0;
      if (phase == 1) vals[i] = reg_mask(cfg_idx_e'(i));
    end
    if (phase == 2 || phase == 5) begin
      // fast seconds and tight thresholds keep the poll logic busy
      vals[REG_BASE_INC] = 32'h00FF_FFFF - $urandom_range(255);
      vals[REG_DRIFT_STEP] = $urandom_range(127);
      vals[REG_OFF_LIMIT] = $urandom_range(70000);
      vals[REG_REF_INT] = $urandom_range(3);
      vals[REG_RETRY_SP] = $urandom_range(5);
      vals[REG_RSP_TMO] = $urandom_range(4);
      vals[REG_BACKOFF] = $urandom_range(300);
      vals[REG_UNSYNC] = $urandom_range(1) ? $urandom : 32'd0;
    end
    if (phase == 3) begin
      vals[REG_BASE_INC]   = 32'(BaseIncReset);
      vals[REG_DRIFT_STEP] = 32'(DriftStepReset);
      vals[REG_OFF_LIMIT]  = OffLimitReset;
      vals[REG_REF_INT]    = 32'(RefIntReset);
      vals[REG_RETRY_SP]   = 32'(RetrySpReset);
      vals[REG_RSP_TMO]    = 32'(RspTmoReset);
      vals[REG_BACKOFF]    = 32'(BackoffReset);
      vals[REG_UNSYNC]     = UnsyncReset;
    end
    for (int i = 0; i < 8; i++) write_register(cfg_idx_e'(i), vals[i]);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold the sender until every expected result has come back
  task automatic wait_for_drain();
    while (pending_cmds.size() != 0 || req_ch.valid || expected_stamps.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    req_ch.valid    = 1'b0;
    req_ch.action   = ACT_TICK;
    req_ch.new_time = '0;
    rsp_ch.ready    = 1'b0;
    clk_cfg.base_increment   = BaseIncReset;
    clk_cfg.drift_step       = DriftStepReset;
    clk_cfg.offset_limit     = OffLimitReset;
    clk_cfg.refresh_interval = RefIntReset;
    clk_cfg.retry_spacing    = RetrySpReset;
    clk_cfg.response_timeout = RspTmoReset;
    clk_cfg.timeout_backoff  = BackoffReset;
    clk_cfg.unsynced_below   = UnsyncReset;
    clock_state  = ClockReset;
    drift_trim   = DriftReset;
    refresh_sec  = RefreshReset;
    last_req_sec = LastReqReset;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    gap_pct   = 20;
    stall_pct = 20;
    queue_directed_cmds();
    wait_for_drain();
    for (int phase = 0; phase < 8; phase++) begin
      program_phase(phase);
      @(negedge clk);
      if (phase == 7) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(2) * 20;
        stall_pct = $urandom_range(2) * 20;
      end
      queue_random_cmds(250);
      wait_for_drain();
    end
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
src/dtc_pkg.sv
src/dtc_if.sv
src/dtc_cfg.sv
src/dtc_core.sv
src/disciplined_timestamp_clock_core.sv
src/dtc_checker.sv
tb/disciplined_timestamp_clock_core_test.sv
